// File: rtl/rvx_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation codes and constants for the RV32I execute stage.
package rvx_pkg;

   localparam int XLEN = 32;
   localparam int SHAMT_W = 5;

   localparam logic [XLEN-1:0] PC_STEP = 32'd4;

   // Operation codes carried in cmd
   localparam logic [4:0] CMD_ADD   = 5'd0;
   localparam logic [4:0] CMD_SUB   = 5'd1;
   localparam logic [4:0] CMD_SLT   = 5'd2;
   localparam logic [4:0] CMD_SLTU  = 5'd3;
   localparam logic [4:0] CMD_AND   = 5'd4;
   localparam logic [4:0] CMD_OR    = 5'd5;
   localparam logic [4:0] CMD_XOR   = 5'd6;
   localparam logic [4:0] CMD_SLL   = 5'd7;
   localparam logic [4:0] CMD_SRL   = 5'd8;
   localparam logic [4:0] CMD_SRA   = 5'd9;
   localparam logic [4:0] CMD_ADDI  = 5'd10;
   localparam logic [4:0] CMD_SLTI  = 5'd11;
   localparam logic [4:0] CMD_SLTIU = 5'd12;
   localparam logic [4:0] CMD_ANDI  = 5'd13;
   localparam logic [4:0] CMD_ORI   = 5'd14;
   localparam logic [4:0] CMD_XORI  = 5'd15;
   localparam logic [4:0] CMD_SLLI  = 5'd16;
   localparam logic [4:0] CMD_SRLI  = 5'd17;
   localparam logic [4:0] CMD_SRAI  = 5'd18;
   localparam logic [4:0] CMD_JALR  = 5'd19;
   localparam logic [4:0] CMD_LOAD  = 5'd20;
   localparam logic [4:0] CMD_LUI   = 5'd21;
   localparam logic [4:0] CMD_AUIPC = 5'd22;
   localparam logic [4:0] CMD_JAL   = 5'd23;
   localparam logic [4:0] CMD_BEQ   = 5'd24;
   localparam logic [4:0] CMD_BNE   = 5'd25;
   localparam logic [4:0] CMD_BLT   = 5'd26;
   localparam logic [4:0] CMD_BLTU  = 5'd27;
   localparam logic [4:0] CMD_BGE   = 5'd28;
   localparam logic [4:0] CMD_BGEU  = 5'd29;
   localparam logic [4:0] CMD_STORE = 5'd30;

   typedef struct packed {
      logic            in_valid;
      logic [4:0]      cmd;
      logic [XLEN-1:0] rs1_value;
      logic [XLEN-1:0] rs2_value;
      logic [XLEN-1:0] imm_value;
      logic [XLEN-1:0] inst_pc;
      logic            predicted_taken;
   } req_type;

   typedef struct packed {
      logic            out_valid;
      logic [XLEN-1:0] result_value;
      logic [XLEN-1:0] mem_address;
      logic            flush;
      logic            redirect_valid;
      logic [XLEN-1:0] redirect_pc;
      logic            branch_resolved;
      logic            branch_taken;
   } rsp_type;

   // Control-flow outcome handed from the branch unit to the top level
   typedef struct packed {
      logic            flush;
      logic            redirect_valid;
      logic [XLEN-1:0] redirect_pc;
      logic            resolved;
      logic            taken;
   } branch_type;

endpackage

// File: rtl/rv32i_execute_alu_branch.sv
`timescale 1ns / 1ps
// RV32I execute stage: ALU, address generation and branch resolution.
// An accepted req beat passes the input register, then the result register.
// Throughput: one beat per cycle while rsp_stall is low; a new beat is taken
//   while a finished result waits in the result register only if the input
//   register is empty.
// Reset: synchronous, active high; clears both stage valid flags only.
module rv32i_execute_alu_branch (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rvx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rvx_pkg::rsp_type rsp_data
);

   // Input register
   logic             req_valid_ff;
   rvx_pkg::req_type req_data_ff;

   // Result register
   logic             rsp_valid_ff;
   rvx_pkg::rsp_type rsp_data_ff;
   rvx_pkg::rsp_type rsp_data_in;

   logic                     rsp_free;
   logic                     req_free;
   logic [rvx_pkg::XLEN-1:0] alu_result;
   logic [rvx_pkg::XLEN-1:0] alu_address;
   rvx_pkg::branch_type      br;

   // Result slot opens when empty or being drained this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // Input slot opens when empty or moving into the result slot
   assign req_free  = !req_valid_ff || rsp_free;
   assign req_stall = !req_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_free) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_free && req_valid) begin
         req_data_ff <= req_data;
      end
   end

   rvx_alu u_alu (
      .req          (req_data_ff),
      .result_value (alu_result),
      .mem_address  (alu_address)
   );

   rvx_branch u_branch (
      .req (req_data_ff),
      .br  (br)
   );

   always_comb begin
      rsp_data_in.out_valid       = req_data_ff.in_valid;
      rsp_data_in.result_value    = alu_result;
      rsp_data_in.mem_address     = alu_address;
      rsp_data_in.flush           = br.flush;
      rsp_data_in.redirect_valid  = br.redirect_valid;
      rsp_data_in.redirect_pc     = br.redirect_pc;
      rsp_data_in.branch_resolved = br.resolved;
      rsp_data_in.branch_taken    = br.taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/rvx_alu.sv
`timescale 1ns / 1ps
// Integer ALU, upper-immediate, link value and load/store address generation.
module rvx_alu (
   input  rvx_pkg::req_type               req,
   output logic [rvx_pkg::XLEN-1:0]       result_value,
   output logic [rvx_pkg::XLEN-1:0]       mem_address
);

   logic [rvx_pkg::XLEN-1:0]    a;
   logic [rvx_pkg::XLEN-1:0]    b;
   logic [rvx_pkg::SHAMT_W-1:0] shamt;
   logic [rvx_pkg::XLEN-1:0]    sum_ab;
   logic [rvx_pkg::XLEN-1:0]    sum_ai;
   logic                        lt_s;
   logic                        lt_u;

   assign a = req.rs1_value;

   // Register ops take rs2, immediate ops take imm
   assign b = (req.cmd <= rvx_pkg::CMD_SRA) ? req.rs2_value : req.imm_value;

   assign shamt  = b[rvx_pkg::SHAMT_W-1:0];
   assign sum_ab = a + b;
   assign sum_ai = a + req.imm_value;
   assign lt_s   = $signed(a) < $signed(b);
   assign lt_u   = a < b;

   always_comb begin
      result_value = '0;
      mem_address  = '0;
      if (req.in_valid) begin
         unique case (req.cmd) inside
            rvx_pkg::CMD_ADD, rvx_pkg::CMD_ADDI: result_value = sum_ab;
            rvx_pkg::CMD_SUB:                    result_value = a - b;
            rvx_pkg::CMD_SLT, rvx_pkg::CMD_SLTI:
               result_value = {{(rvx_pkg::XLEN-1){1'b0}}, lt_s};
            rvx_pkg::CMD_SLTU, rvx_pkg::CMD_SLTIU:
               result_value = {{(rvx_pkg::XLEN-1){1'b0}}, lt_u};
            rvx_pkg::CMD_AND, rvx_pkg::CMD_ANDI: result_value = a & b;
            rvx_pkg::CMD_OR, rvx_pkg::CMD_ORI:   result_value = a | b;
            rvx_pkg::CMD_XOR, rvx_pkg::CMD_XORI: result_value = a ^ b;
            rvx_pkg::CMD_SLL, rvx_pkg::CMD_SLLI: result_value = a << shamt;
            rvx_pkg::CMD_SRL, rvx_pkg::CMD_SRLI: result_value = a >> shamt;
            rvx_pkg::CMD_SRA, rvx_pkg::CMD_SRAI:
               result_value = $unsigned($signed(a) >>> shamt);
            rvx_pkg::CMD_JALR, rvx_pkg::CMD_JAL:
               result_value = req.inst_pc + rvx_pkg::PC_STEP;
            rvx_pkg::CMD_LUI:   result_value = req.imm_value;
            rvx_pkg::CMD_AUIPC: result_value = req.inst_pc + req.imm_value;
            rvx_pkg::CMD_LOAD, rvx_pkg::CMD_STORE: mem_address = sum_ai;
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/rvx_branch.sv
`timescale 1ns / 1ps
// Jump targets and conditional branch resolution against the prediction.
module rvx_branch (
   input  rvx_pkg::req_type    req,
   output rvx_pkg::branch_type br
);

   logic [rvx_pkg::XLEN-1:0] a;
   logic [rvx_pkg::XLEN-1:0] b;
   logic [rvx_pkg::XLEN-1:0] jalr_sum;
   logic [rvx_pkg::XLEN-1:0] pc_imm;
   logic [rvx_pkg::XLEN-1:0] pc_next;
   logic                     eq;
   logic                     lt_s;
   logic                     lt_u;
   logic                     taken;

   assign a        = req.rs1_value;
   assign b        = req.rs2_value;
   assign jalr_sum = a + req.imm_value;
   assign pc_imm   = req.inst_pc + req.imm_value;
   assign pc_next  = req.inst_pc + rvx_pkg::PC_STEP;
   assign eq       = a == b;
   assign lt_s     = $signed(a) < $signed(b);
   assign lt_u     = a < b;

   always_comb begin
      unique case (req.cmd) inside
         rvx_pkg::CMD_BEQ:  taken = eq;
         rvx_pkg::CMD_BNE:  taken = !eq;
         rvx_pkg::CMD_BLT:  taken = lt_s;
         rvx_pkg::CMD_BLTU: taken = lt_u;
         rvx_pkg::CMD_BGE:  taken = !lt_s;
         rvx_pkg::CMD_BGEU: taken = !lt_u;
         default:           taken = 1'b0;
      endcase
   end

   always_comb begin
      br = '0;
      if (req.in_valid) begin
         unique case (req.cmd) inside
            rvx_pkg::CMD_JALR: begin
               br.flush          = 1'b1;
               br.redirect_valid = 1'b1;
               br.redirect_pc    = {jalr_sum[rvx_pkg::XLEN-1:1], 1'b0};
            end
            rvx_pkg::CMD_JAL: begin
               br.flush          = 1'b1;
               br.redirect_valid = 1'b1;
               br.redirect_pc    = pc_imm;
            end
            [rvx_pkg::CMD_BEQ:rvx_pkg::CMD_BGEU]: begin
               br.resolved = 1'b1;
               br.taken    = taken;
               // mispredict: fix up fetch toward the actual path
               if (taken != req.predicted_taken) begin
                  br.flush          = 1'b1;
                  br.redirect_valid = 1'b1;
                  br.redirect_pc    = taken ? pc_imm : pc_next;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
